[rtl/delayed_setpoint_alarm_core_macros.svh]
// Assertion macros used by the checker file.
`ifndef DELAYED_SETPOINT_ALARM_CORE_MACROS_SVH
`define DELAYED_SETPOINT_ALARM_CORE_MACROS_SVH

// Check a property on every rising edge outside of reset.
`define DSA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define DSA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/dsa_pkg.sv]
`timescale 1ns / 1ps

package dsa_pkg;

    localparam int TICK_WIDTH = 32;
    localparam int TEMP_W     = 16;
    localparam int DELAY_W    = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    localparam logic [DELAY_W-1:0] ALERT_DELAY_RST   = 32'd1000;
    localparam logic [DELAY_W-1:0] CLEAR_DELAY_RST   = 32'd1000;
    localparam logic [DELAY_W-1:0] STARTUP_DELAY_RST = 32'd1000;
    localparam logic [DELAY_W-1:0] LED_PERIOD_RST    = 32'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT      = 3'd0,
        REG_ALERT_DELAY   = 3'd1,
        REG_CLEAR_DELAY   = 3'd2,
        REG_STARTUP_DELAY = 3'd3,
        REG_LED_PERIOD    = 3'd4
    } cfg_reg_t;

    typedef enum logic [2:0] {
        PH_ABOVE      = 3'd0,
        PH_LOW        = 3'd1,
        PH_ACTIVATE   = 3'd2,
        PH_LOW_WAIT   = 3'd3,
        PH_DEACTIVATE = 3'd4
    } phase_t;

    typedef struct packed {
        logic [TEMP_W-1:0]  setpoint;
        logic [DELAY_W-1:0] alert_delay;
        logic [DELAY_W-1:0] clear_delay;
        logic [DELAY_W-1:0] led_period;
    } cfg_t;

    typedef struct packed {
        logic              temp_valid;
        logic [TEMP_W-1:0] temperature;
    } in_item_t;

    typedef struct packed {
        logic       relay_closed;
        logic       alert_led;
        logic [2:0] alarm_state;
    } out_item_t;

    // A zero period toggles every tick.
    function automatic logic [DELAY_W-1:0] blink_load(input logic [DELAY_W-1:0] period);
        blink_load = (period == '0) ? DELAY_W'(1) : period;
    endfunction

endpackage

[rtl/dsa_cfg.sv]
`timescale 1ns / 1ps

module dsa_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [dsa_pkg::CFG_IDX_W-1:0]       index,
    input  logic [dsa_pkg::CFG_DATA_W-1:0]      data,
    output dsa_pkg::cfg_t                       cfg
);

    dsa_pkg::cfg_t cfg_reg;
    dsa_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (index)
                dsa_pkg::REG_SETPOINT:
                    cfg_next.setpoint = data[dsa_pkg::TEMP_W-1:0];
                dsa_pkg::REG_ALERT_DELAY:
                    cfg_next.alert_delay = data[dsa_pkg::DELAY_W-1:0];
                dsa_pkg::REG_CLEAR_DELAY:
                    cfg_next.clear_delay = data[dsa_pkg::DELAY_W-1:0];
                dsa_pkg::REG_LED_PERIOD:
                    cfg_next.led_period = data[dsa_pkg::DELAY_W-1:0];
                // Startup delay only matters at reset, which restores its
                // default, so a write to it, or to an unused index, is dropped.
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setpoint     <= '0;
            cfg_reg.alert_delay  <= dsa_pkg::ALERT_DELAY_RST;
            cfg_reg.clear_delay  <= dsa_pkg::CLEAR_DELAY_RST;
            cfg_reg.led_period   <= dsa_pkg::LED_PERIOD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/dsa_step.sv]
`timescale 1ns / 1ps

module dsa_step (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  dsa_pkg::in_item_t    sample,
    input  dsa_pkg::cfg_t        cfg,
    output dsa_pkg::out_item_t   result
);

    dsa_pkg::phase_t                     phase_reg,       phase_next;
    logic [dsa_pkg::TEMP_W-1:0]          last_temp_reg,   last_temp_next;
    logic [dsa_pkg::TICK_WIDTH-1:0]      delay_reg,       delay_next;
    logic                                clear_timing_reg, clear_timing_next;
    logic                                relay_reg,       relay_next;
    logic                                led_reg,         led_next;
    logic                                blink_run_reg,   blink_run_next;
    logic [dsa_pkg::DELAY_W-1:0]         blink_reg,       blink_next;

    logic                                below;
    logic [dsa_pkg::DELAY_W-1:0]         blink_dec;
    logic [dsa_pkg::TICK_WIDTH-1:0]      delay_dec;

    always_comb
    begin
        last_temp_next    = sample.temp_valid ? sample.temperature : last_temp_reg;
        phase_next        = phase_reg;
        clear_timing_next = clear_timing_reg;
        relay_next        = relay_reg;
        led_next          = led_reg;
        blink_run_next    = blink_run_reg;
        blink_next        = blink_reg;

        // Blink timer: count down, toggle and reload on reaching zero.
        blink_dec = (blink_reg != '0) ? blink_reg - 1'b1 : blink_reg;
        if (blink_run_reg)
        begin
            blink_next = blink_dec;
            if (blink_dec == '0)
            begin
                led_next   = !led_reg;
                blink_next = dsa_pkg::blink_load(cfg.led_period);
            end
        end

        delay_dec  = (delay_reg != '0) ? delay_reg - 1'b1 : delay_reg;
        delay_next = delay_dec;

        below = last_temp_next < cfg.setpoint;

        case (phase_reg)
            dsa_pkg::PH_ABOVE:
            begin
                if (below)
                begin
                    phase_next = dsa_pkg::PH_LOW;
                    delay_next = dsa_pkg::TICK_WIDTH'(cfg.alert_delay);
                end
            end
            dsa_pkg::PH_LOW:
            begin
                if (!below)
                    phase_next = dsa_pkg::PH_DEACTIVATE;
                else if (delay_dec == '0)
                    phase_next = dsa_pkg::PH_ACTIVATE;
            end
            dsa_pkg::PH_ACTIVATE:
            begin
                relay_next        = 1'b0;
                blink_run_next    = 1'b1;
                blink_next        = dsa_pkg::blink_load(cfg.led_period);
                clear_timing_next = 1'b0;
                phase_next        = dsa_pkg::PH_LOW_WAIT;
            end
            dsa_pkg::PH_LOW_WAIT:
            begin
                if (below)
                    clear_timing_next = 1'b0;
                else if (!clear_timing_reg)
                begin
                    delay_next        = dsa_pkg::TICK_WIDTH'(cfg.clear_delay);
                    clear_timing_next = 1'b1;
                end
                else if (delay_dec == '0)
                    phase_next = dsa_pkg::PH_DEACTIVATE;
            end
            dsa_pkg::PH_DEACTIVATE:
            begin
                clear_timing_next = 1'b0;
                relay_next        = 1'b1;
                blink_run_next    = 1'b0;
                led_next          = 1'b0;
                phase_next        = dsa_pkg::PH_ABOVE;
            end
            default:
                phase_next = dsa_pkg::PH_ABOVE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= dsa_pkg::PH_LOW;
            last_temp_reg    <= '0;
            delay_reg        <= dsa_pkg::TICK_WIDTH'(dsa_pkg::STARTUP_DELAY_RST);
            clear_timing_reg <= 1'b0;
            relay_reg        <= 1'b0;
            led_reg          <= 1'b0;
            blink_run_reg    <= 1'b0;
            blink_reg        <= '0;
        end
        else if (advance)
        begin
            phase_reg        <= phase_next;
            last_temp_reg    <= last_temp_next;
            delay_reg        <= delay_next;
            clear_timing_reg <= clear_timing_next;
            relay_reg        <= relay_next;
            led_reg          <= led_next;
            blink_run_reg    <= blink_run_next;
            blink_reg        <= blink_next;
        end
    end

    assign result.relay_closed = relay_next;
    assign result.alert_led    = led_next;
    assign result.alarm_state  = phase_next;

endmodule

[rtl/delayed_setpoint_alarm_core.sv]
`timescale 1ns / 1ps
// A sample is held in the sample register, then its result in the result register.
// Throughput: one sample per cycle while the result side accepts; the alarm state
// update for a sample is combinational between the sample and result registers.
// Reset (rst_n low, asynchronous): both stages empty, phase low, startup delay
// of 1000 ticks loaded, relay open, LED off, registers at their defaults.

module delayed_setpoint_alarm_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 sample_valid,
    output logic                                 sample_ready,
    input  dsa_pkg::in_item_t                    sample,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output dsa_pkg::out_item_t                   result,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [dsa_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [dsa_pkg::CFG_DATA_W-1:0]       cfg_data
);

    dsa_pkg::cfg_t      cfg;
    dsa_pkg::in_item_t  s_data_reg;
    dsa_pkg::out_item_t r_data_reg;
    dsa_pkg::out_item_t step_result;
    logic               s_valid_reg, s_valid_next;
    logic               r_valid_reg, r_valid_next;
    logic               advance;
    logic               take;

    assign cfg_ready = 1'b1;

    dsa_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (cfg_valid && cfg_ready),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    dsa_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .sample  (s_data_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    // Advance the held sample whenever the result register is free or draining.
    assign advance      = s_valid_reg && (!r_valid_reg || result_ready);
    assign sample_ready = !s_valid_reg || advance;
    assign take         = sample_valid && sample_ready;

    always_comb
    begin
        s_valid_next = take || (s_valid_reg && !advance);
        r_valid_next = advance || (r_valid_reg && !result_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
        end
        else
        begin
            s_valid_reg <= s_valid_next;
            r_valid_reg <= r_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            s_data_reg <= sample;
        if (advance)
            r_data_reg <= step_result;
    end

    assign result_valid = r_valid_reg;
    assign result       = r_data_reg;

endmodule

[rtl/dsa_checker.sv]
`timescale 1ns / 1ps
`include "delayed_setpoint_alarm_core_macros.svh"

module dsa_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            result_valid,
    input logic                            result_ready,
    input dsa_pkg::out_item_t              result
);

    // Hold a stalled result.
    `DSA_ASSERT(a_result_hold, clk, rst_n,
        result_valid && !result_ready |=> result_valid && $stable(result),
        "stalled result changed")

    // Reset empties the result register by the following edge.
    `DSA_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !result_valid,
        "result valid during reset")

    // Above is only reached through deactivate, which closes the relay.
    `DSA_ASSERT(a_above_closed, clk, rst_n,
        result_valid && result.alarm_state == dsa_pkg::PH_ABOVE
            |-> result.relay_closed && !result.alert_led,
        "relay open or LED on in above")

    // The LED only blinks once the alert has fired.
    `DSA_ASSERT(a_led_idle, clk, rst_n,
        result_valid && (result.alarm_state == dsa_pkg::PH_LOW
            || result.alarm_state == dsa_pkg::PH_ACTIVATE) |-> !result.alert_led,
        "LED on before alert")

    `DSA_ASSERT(a_wait_open, clk, rst_n,
        result_valid && result.alarm_state == dsa_pkg::PH_LOW_WAIT |-> !result.relay_closed,
        "relay closed while alert active")

endmodule

bind delayed_setpoint_alarm_core dsa_checker u_dsa_checker (.*);

[tb/sv/tb_delayed_setpoint_alarm_core.sv]
`timescale 1ns / 1ps

module tb_delayed_setpoint_alarm_core;

    localparam int HOLD_CYCLES = 80;
    localparam int SETTING_ITEMS = 85;
    localparam logic [dsa_pkg::CFG_IDX_W-1:0] FIRST_UNUSED_REG = 3'd5;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic sample_valid = 1'b0;
    logic sample_ready;
    dsa_pkg::in_item_t sample = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    dsa_pkg::out_item_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [dsa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [dsa_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Alarm model state and its copy of the registers
    dsa_pkg::cfg_t alarm_cfg;
    logic [dsa_pkg::DELAY_W-1:0] startup_delay;
    dsa_pkg::phase_t cur_phase;
    logic [dsa_pkg::TEMP_W-1:0] cur_temp;
    logic [dsa_pkg::DELAY_W-1:0] delay_cnt;
    logic clear_armed;
    logic relay_on;
    logic led_on;
    logic blink_on;
    logic [dsa_pkg::DELAY_W-1:0] blink_cnt;

    dsa_pkg::out_item_t pending_alarm_outputs[$];
    int fail_count = 0;
    int items_sent = 0;
    bit idle_on = 1'b1;
    bit hold_results = 1'b0;

    delayed_setpoint_alarm_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [dsa_pkg::DELAY_W-1:0] blink_reload();
        return (alarm_cfg.led_period == '0) ? dsa_pkg::DELAY_W'(1) : alarm_cfg.led_period;
    endfunction

    // Advance the alarm by one tick and return the outputs after the update.
    function automatic dsa_pkg::out_item_t predict_alarm(input dsa_pkg::in_item_t s);
        logic below;
        dsa_pkg::out_item_t o;
        if (s.temp_valid)
            cur_temp = s.temperature;
        if (blink_on)
        begin
            if (blink_cnt != '0)
                blink_cnt = blink_cnt - 1'b1;
            if (blink_cnt == '0)
            begin
                led_on = ~led_on;
                blink_cnt = blink_reload();
            end
        end
        if (delay_cnt != '0)
            delay_cnt = delay_cnt - 1'b1;
        below = cur_temp < alarm_cfg.setpoint;
        case (cur_phase)
            dsa_pkg::PH_ABOVE:
            begin
                if (below)
                begin
                    cur_phase = dsa_pkg::PH_LOW;
                    delay_cnt = alarm_cfg.alert_delay;
                end
            end
            dsa_pkg::PH_LOW:
            begin
                if (below)
                begin
                    if (delay_cnt == '0)
                        cur_phase = dsa_pkg::PH_ACTIVATE;
                end
                else
                    cur_phase = dsa_pkg::PH_DEACTIVATE;
            end
            dsa_pkg::PH_ACTIVATE:
            begin
                relay_on = 1'b0;
                blink_on = 1'b1;
                blink_cnt = blink_reload();
                clear_armed = 1'b0;
                cur_phase = dsa_pkg::PH_LOW_WAIT;
            end
            dsa_pkg::PH_LOW_WAIT:
            begin
                if (!below)
                begin
                    if (!clear_armed)
                    begin
                        delay_cnt = alarm_cfg.clear_delay;
                        clear_armed = 1'b1;
                    end
                    else if (delay_cnt == '0)
                        cur_phase = dsa_pkg::PH_DEACTIVATE;
                end
                else
                    clear_armed = 1'b0;
            end
            dsa_pkg::PH_DEACTIVATE:
            begin
                clear_armed = 1'b0;
                relay_on = 1'b1;
                blink_on = 1'b0;
                led_on = 1'b0;
                cur_phase = dsa_pkg::PH_ABOVE;
            end
            default: cur_phase = dsa_pkg::PH_ABOVE;
        endcase
        o.relay_closed = relay_on;
        o.alert_led = led_on;
        o.alarm_state = cur_phase;
        return o;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && sample_valid && sample_ready)
            pending_alarm_outputs.push_back(predict_alarm(sample));
    end

    always @(posedge clk)
    begin : check_results
        dsa_pkg::out_item_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_alarm_outputs.size() == 0)
            begin
                $error("unexpected result transfer: %p", result);
                fail_count++;
            end
            else
            begin
                want = pending_alarm_outputs.pop_front();
                if (result.relay_closed !== want.relay_closed)
                begin
                    $error("relay_closed: expected %0d, got %0d",
                           want.relay_closed, result.relay_closed);
                    fail_count++;
                end
                if (result.alert_led !== want.alert_led)
                begin
                    $error("alert_led: expected %0d, got %0d", want.alert_led, result.alert_led);
                    fail_count++;
                end
                if (result.alarm_state !== want.alarm_state)
                begin
                    $error("alarm_state: expected %0d, got %0d",
                           want.alarm_state, result.alarm_state);
                    fail_count++;
                end
            end
        end
    end

    // Result side: random stalls, always ready when idle is off, or one long hold-off on request.
    initial
    begin : drive_result_ready
        int stall_left;
        int r;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_results)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_results = 1'b0;
            end
            else if (!idle_on)
                result_ready <= 1'b1;
            else if (stall_left > 0)
            begin
                result_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 75)
                    result_ready <= 1'b1;
                else
                begin
                    result_ready <= 1'b0;
                    stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(9, 29);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_sample(input dsa_pkg::in_item_t item);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample <= item;
        sample_valid <= 1'b1;
        do @(posedge clk); while (!sample_ready);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_tick(input logic valid, input logic [dsa_pkg::TEMP_W-1:0] temp);
        dsa_pkg::in_item_t item;
        item.temp_valid = valid;
        item.temperature = temp;
        send_sample(item);
    endtask

    function automatic logic [dsa_pkg::TEMP_W-1:0] pick_temp(input bit want_below);
        int r;
        r = $urandom_range(0, 9);
        if (want_below && alarm_cfg.setpoint != '0)
        begin
            if (r < 2)
                return alarm_cfg.setpoint - 1'b1;
            return dsa_pkg::TEMP_W'($urandom_range(0, alarm_cfg.setpoint - 1));
        end
        if (!want_below)
        begin
            if (r < 2)
                return alarm_cfg.setpoint;
            return dsa_pkg::TEMP_W'($urandom_range(alarm_cfg.setpoint, 16'hFFFF));
        end
        return dsa_pkg::TEMP_W'($urandom);
    endfunction

    // Mostly fresh readings on the wanted side; some ticks carry no reading.
    task automatic send_reading(input bit want_below);
        if ($urandom_range(0, 99) < 15)
            send_tick(1'b0, dsa_pkg::TEMP_W'($urandom));
        else
            send_tick(1'b1, pick_temp(want_below));
    endtask

    task automatic wait_idle();
        sample_valid <= 1'b0;
        while (pending_alarm_outputs.size() != 0) @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input logic [dsa_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dsa_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            dsa_pkg::REG_SETPOINT:      alarm_cfg.setpoint = data[dsa_pkg::TEMP_W-1:0];
            dsa_pkg::REG_ALERT_DELAY:   alarm_cfg.alert_delay = data;
            dsa_pkg::REG_CLEAR_DELAY:   alarm_cfg.clear_delay = data;
            dsa_pkg::REG_STARTUP_DELAY: startup_delay = data;
            dsa_pkg::REG_LED_PERIOD:    alarm_cfg.led_period = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [dsa_pkg::DELAY_W-1:0] random_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(0, 12);
        if (r < 96)
            return $urandom_range(13, 60);
        if (r < 98)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    function automatic logic [dsa_pkg::DELAY_W-1:0] random_blink();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(0, 6);
        if (r < 97)
            return $urandom_range(7, 40);
        return $urandom;
    endfunction

    // Setpoint zero: nothing is below it, so the machine drops to above.
    task automatic test_power_up_defaults();
        send_tick(1'b1, 16'h0000);
        send_tick(1'b0, 16'hFFFF);
        send_tick(1'b1, 16'hFFFF);
        wait_idle();
    endtask

    task automatic test_zero_delays_fast_blink();
        write_reg(dsa_pkg::REG_SETPOINT, 32'hFFFF_FFFF);
        write_reg(dsa_pkg::REG_ALERT_DELAY, 32'h0);
        write_reg(dsa_pkg::REG_CLEAR_DELAY, 32'h0);
        write_reg(dsa_pkg::REG_LED_PERIOD, 32'h0);
        send_tick(1'b1, 16'h0000);
        send_tick(1'b0, 16'hFFFF);
        send_tick(1'b1, 16'hFFFE);
        send_tick(1'b1, 16'h0001);
        send_tick(1'b1, 16'hFFFF);
        send_tick(1'b0, 16'h0000);
        send_tick(1'b1, 16'hFFFF);
        wait_idle();
    endtask

    task automatic test_maximum_delays();
        write_reg(dsa_pkg::REG_SETPOINT, 32'h0000_8000);
        write_reg(dsa_pkg::REG_CLEAR_DELAY, 32'hFFFF_FFFF);
        write_reg(dsa_pkg::REG_LED_PERIOD, 32'hFFFF_FFFF);
        send_tick(1'b1, 16'h7FFF);
        send_tick(1'b1, 16'h7FFF);
        send_tick(1'b1, 16'h7FFF);
        send_tick(1'b1, 16'h8000);
        send_tick(1'b1, 16'hFFFF);
        send_tick(1'b0, 16'h0000);
        wait_idle();
        // New delays apply only on the next load
        write_reg(dsa_pkg::REG_ALERT_DELAY, 32'hFFFF_FFFF);
        write_reg(dsa_pkg::REG_CLEAR_DELAY, 32'h0);
        send_tick(1'b1, 16'h0000);
        send_tick(1'b1, 16'h8000);
        send_tick(1'b1, 16'h8000);
        send_tick(1'b1, 16'h8000);
        send_tick(1'b1, 16'h0000);
        send_tick(1'b1, 16'h0000);
        send_tick(1'b1, 16'h8000);
        send_tick(1'b1, 16'h8000);
        wait_idle();
    endtask

    // Startup delay is latched only at reset; unused indexes are dropped.
    task automatic test_startup_and_unused_writes();
        write_reg(dsa_pkg::REG_STARTUP_DELAY, 32'hFFFF_FFFF);
        write_reg(dsa_pkg::REG_STARTUP_DELAY, 32'h0);
        write_reg(FIRST_UNUSED_REG + dsa_pkg::CFG_IDX_W'($urandom_range(0, 2)), $urandom);
        send_tick(1'b1, 16'h1234);
        send_tick(1'b0, 16'hEDCB);
        wait_idle();
    endtask

    task automatic test_output_backpressure();
        write_reg(dsa_pkg::REG_SETPOINT, 32'h0000_4000);
        write_reg(dsa_pkg::REG_ALERT_DELAY, 32'd3);
        write_reg(dsa_pkg::REG_CLEAR_DELAY, 32'd2);
        write_reg(dsa_pkg::REG_LED_PERIOD, 32'd2);
        idle_on = 1'b0;
        hold_results = 1'b1;
        repeat (20) send_reading(1'b1);
        repeat (20) send_reading(1'b0);
        wait_idle();
        idle_on = 1'b1;
    endtask

    task automatic test_random_settings();
        int start;
        int r;
        int below_len;
        int above_len;
        logic [dsa_pkg::TEMP_W-1:0] sp;
        for (int k = 0; k < 6; k++)
        begin
            case (k)
                1: sp = 16'hFFFF;
                2: sp = 16'h0001;
                default: sp = dsa_pkg::TEMP_W'($urandom);
            endcase
            write_reg(dsa_pkg::REG_SETPOINT, {16'($urandom), sp});
            write_reg(dsa_pkg::REG_ALERT_DELAY, random_delay());
            write_reg(dsa_pkg::REG_CLEAR_DELAY, random_delay());
            write_reg(dsa_pkg::REG_STARTUP_DELAY, $urandom);
            write_reg(dsa_pkg::REG_LED_PERIOD, random_blink());
            idle_on = (k != 3);
            start = items_sent;
            while (items_sent - start < SETTING_ITEMS)
            begin
                r = $urandom_range(0, 9);
                if (r < 7)
                begin
                    // full alert and clear cycle
                    below_len = ((alarm_cfg.alert_delay > 40) ? 40 : alarm_cfg.alert_delay)
                                + $urandom_range(2, 6);
                    above_len = ((alarm_cfg.clear_delay > 40) ? 40 : alarm_cfg.clear_delay)
                                + $urandom_range(2, 5);
                    repeat (below_len) send_reading(1'b1);
                    repeat (above_len) send_reading(1'b0);
                end
                else if (r == 7)
                begin
                    // interrupt the qualification early
                    repeat ($urandom_range(1, 4)) send_reading(1'b1);
                    repeat ($urandom_range(1, 3)) send_reading(1'b0);
                end
                else
                    repeat (8) send_tick(1'($urandom), dsa_pkg::TEMP_W'($urandom));
            end
            wait_idle();
        end
        idle_on = 1'b1;
    endtask

    initial
    begin : run_tests
        int drain;
        alarm_cfg.setpoint = '0;
        alarm_cfg.alert_delay = dsa_pkg::ALERT_DELAY_RST;
        alarm_cfg.clear_delay = dsa_pkg::CLEAR_DELAY_RST;
        alarm_cfg.led_period = dsa_pkg::LED_PERIOD_RST;
        startup_delay = dsa_pkg::STARTUP_DELAY_RST;
        cur_phase = dsa_pkg::PH_LOW;
        cur_temp = '0;
        delay_cnt = startup_delay;
        clear_armed = 1'b0;
        relay_on = 1'b0;
        led_on = 1'b0;
        blink_on = 1'b0;
        blink_cnt = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_power_up_defaults();
        test_zero_delays_fast_blink();
        test_maximum_delays();
        test_startup_and_unused_writes();
        test_output_backpressure();
        test_random_settings();

        sample_valid <= 1'b0;
        drain = 0;
        while (pending_alarm_outputs.size() != 0 && drain < 5000)
        begin
            @(negedge clk);
            drain++;
        end
        if (pending_alarm_outputs.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_alarm_outputs.size());
            fail_count++;
        end
        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
